### hw/rtl/ksort_pkg.sv
// Shared types and codes for the keyed item sorter.
// Used by ksort_cell and keyed_item_sorter; no other dependencies.
package ksort_pkg;

   localparam int MaxItemsDefault    = 256;
   localparam int KeyBitsDefault     = 24;
   localparam int PayloadBitsDefault = 16;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain at once
   typedef struct packed {
      logic insert;   // place the new pair, shift the larger ones right
      logic remove;   // shift everything one place left
   } cell_ctrl_type;

endpackage

### hw/rtl/ksort_cell.sv
// One compare-and-shift cell of the sorting chain: holds one key and payload.
// Depends on ksort_pkg for the broadcast command struct.
module ksort_cell #(
   parameter int IDX          = 0,
   parameter int CNT_BITS     = 9,
   parameter int KEY_BITS     = 24,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                          clock,
   input  ksort_pkg::cell_ctrl_type      ctrl,
   input  logic [CNT_BITS-1:0]           count,
   input  logic signed [KEY_BITS-1:0]    new_key,
   input  logic [PAYLOAD_BITS-1:0]       new_payload,
   input  logic                          left_keep,
   input  logic signed [KEY_BITS-1:0]    left_key,
   input  logic [PAYLOAD_BITS-1:0]       left_payload,
   input  logic signed [KEY_BITS-1:0]    right_key,
   input  logic [PAYLOAD_BITS-1:0]       right_payload,
   output logic                          keep,
   output logic signed [KEY_BITS-1:0]    key,
   output logic [PAYLOAD_BITS-1:0]       payload
);
   import ksort_pkg::*;

   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]    payload_ff, payload_in;
   logic                       occupied;

   assign occupied = (count > CNT_BITS'(IDX));
   // Equal keys stay put so a new pair lands behind them
   assign keep     = occupied && (key_ff <= new_key);

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            if (left_keep) begin
               key_in     = new_key;
               payload_in = new_payload;
            end else begin
               key_in     = left_key;
               payload_in = left_payload;
            end
         end
      end else if (ctrl.remove) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

### hw/rtl/keyed_item_sorter.sv
// Top level of the keyed item sorter: a chain of ksort_cell instances plus count and
// result register. Depends on ksort_pkg and ksort_cell.
//
// Usage:
//  - req channel: opcode OP_LOAD inserts (sort_key, payload); OP_READ removes the pair
//    with the smallest signed key. Equal keys leave in load order.
//  - rsp channel: one transfer per read, and one per load that finds the store full.
//    A successful load gives no response. status tells ok, read while empty, or
//    load dropped; key, payload and is_last are zero unless status is ok.
//  - Every cell compares its key with the incoming key in parallel, so the chain needs
//    no sequential search: one request per cycle, limited only by the
//    response register. A response appears in the cycle after its request transfer.
//  - When a response waits under rsp_stall, req_stall is raised and the store holds.
//  - Synchronous reset empties the store at once (count cleared); cell contents are
//    not cleared, as only occupied cells are ever read.
module keyed_item_sorter #(
   parameter int MAX_ITEMS    = ksort_pkg::MaxItemsDefault,
   parameter int KEY_BITS     = ksort_pkg::KeyBitsDefault,
   parameter int PAYLOAD_BITS = ksort_pkg::PayloadBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic signed [KEY_BITS-1:0]  req_sort_key,
   input  logic [PAYLOAD_BITS-1:0]     req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [KEY_BITS-1:0]  rsp_out_key,
   output logic [PAYLOAD_BITS-1:0]     rsp_out_payload,
   output logic                        rsp_is_last,
   output logic [1:0]                  rsp_status
);
   import ksort_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

   logic signed [KEY_BITS-1:0] cell_key [MAX_ITEMS];
   logic [PAYLOAD_BITS-1:0]    cell_payload [MAX_ITEMS];
   logic                       cell_keep [MAX_ITEMS];

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_BITS-1:0]    rsp_payload_ff, rsp_payload_in;
   logic                rsp_last_ff, rsp_last_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic          req_take;
   logic          is_full, is_empty;
   cell_ctrl_type ctrl;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_BITS'(MAX_ITEMS));
   assign is_empty  = (count_ff == '0);

   assign ctrl.insert = req_take && (req_opcode == OP_LOAD) && !is_full;
   assign ctrl.remove = req_take && (req_opcode == OP_READ) && !is_empty;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                       l_keep;
      logic signed [KEY_BITS-1:0] l_key, r_key;
      logic [PAYLOAD_BITS-1:0]    l_payload, r_payload;

      if (i == 0) begin : g_head
         assign l_keep    = 1'b1;
         assign l_key     = '0;
         assign l_payload = '0;
      end else begin : g_body
         assign l_keep    = cell_keep[i-1];
         assign l_key     = cell_key[i-1];
         assign l_payload = cell_payload[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign r_key     = '0;
         assign r_payload = '0;
      end else begin : g_inner
         assign r_key     = cell_key[i+1];
         assign r_payload = cell_payload[i+1];
      end

      ksort_cell #(
         .IDX          (i),
         .CNT_BITS     (CNT_BITS),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count_ff),
         .new_key       (req_sort_key),
         .new_payload   (req_payload),
         .left_keep     (l_keep),
         .left_key      (l_key),
         .left_payload  (l_payload),
         .right_key     (r_key),
         .right_payload (r_payload),
         .keep          (cell_keep[i]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      if (req_take) begin
         unique case (opcode_type'(req_opcode))
            OP_LOAD: begin
               if (is_full) begin
                  rsp_valid_in   = 1'b1;
                  rsp_key_in     = '0;
                  rsp_payload_in = '0;
                  rsp_last_in    = 1'b0;
                  rsp_status_in  = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_READ: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_key_in     = '0;
                  rsp_payload_in = '0;
                  rsp_last_in    = 1'b0;
                  rsp_status_in  = STATUS_EMPTY;
               end else begin
                  rsp_key_in     = cell_key[0];
                  rsp_payload_in = cell_payload[0];
                  rsp_last_in    = (count_ff == CNT_BITS'(1));
                  rsp_status_in  = STATUS_OK;
                  count_in       = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

   // Store never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ITEMS))
      else $error("stored count exceeds capacity");

   // Head of the chain stays ordered
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_BITS'(2)) |-> (cell_key[0] <= cell_key[1]))
      else $error("first two stored keys out of order");

   // A read of a non-empty store returns the head pair
   a_read_head: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> (rsp_valid_ff && (rsp_status_ff == STATUS_OK)
                       && (rsp_key_ff == $past(cell_key[0]))
                       && (count_ff == $past(count_ff) - 1'b1)))
      else $error("read did not return the head pair");

   // A load into a full store is reported and leaves the count alone
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_opcode == OP_LOAD) && is_full)
         |=> (rsp_valid_ff && (rsp_status_ff == STATUS_FULL) && $stable(count_ff)))
      else $error("load into full store not reported");

endmodule
